[hw/rtl/bmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_pkg: shared constants for the binary matrix canonicalizer.
// Holds the key widths, the lane and merge tree sizes, and the table of the
// twenty-four column orderings, one per lane.
// ----------------------------------------------------------------------------
package bmc_pkg;

	localparam int ROW_COUNT_DEF = 8;
	localparam int NIBBLE_W      = 4;
	localparam int KEY_W         = 32;
	localparam int LANE_COUNT    = 24;
	localparam int MERGE_WIDTH   = 32;
	localparam int MERGE_LEVELS  = $clog2(MERGE_WIDTH);
	localparam int LATENCY       = 2 + MERGE_LEVELS;

	// Each entry is {p0, p1, p2, p3}: output column o takes input column p[o].
	localparam logic [7:0] PERM_TABLE [LANE_COUNT] = '{
		8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
		8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
		8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
		8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
		8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
		8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
	};

endpackage

[hw/rtl/bmc_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_lane: one column ordering.
// Permutes the columns of every row, ranks the rows and packs them in
// ascending order, smallest row in the most significant nibble.
// ----------------------------------------------------------------------------
module bmc_lane #(
	parameter int ROW_COUNT  = bmc_pkg::ROW_COUNT_DEF,
	parameter int LANE_INDEX = 0
) (
	input  logic                                   clk,
	input  logic [bmc_pkg::KEY_W-1:0]              key_s1,
	output logic [bmc_pkg::NIBBLE_W*ROW_COUNT-1:0] key_s2
);

	localparam int KW = bmc_pkg::NIBBLE_W * ROW_COUNT;
	localparam int RW = $clog2(ROW_COUNT);
	localparam logic [7:0] PERM = bmc_pkg::PERM_TABLE[LANE_INDEX];

	logic [bmc_pkg::NIBBLE_W-1:0] row   [ROW_COUNT];
	logic [bmc_pkg::NIBBLE_W-1:0] remap [ROW_COUNT];
	logic [RW-1:0]                rank  [ROW_COUNT];
	logic [KW-1:0]                sorted;

	for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
		localparam int SH = bmc_pkg::NIBBLE_W * (ROW_COUNT - 1 - r);
		if (SH < bmc_pkg::KEY_W) begin : g_in
			assign row[r] = key_s1[SH +: bmc_pkg::NIBBLE_W];
		end else begin : g_zero
			assign row[r] = '0;
		end
		for (genvar o = 0; o < bmc_pkg::NIBBLE_W; o++) begin : g_col
			assign remap[r][o] = row[r][PERM[7-2*o -: 2]];
		end
	end

	// Rank is the number of rows that sort ahead; ties go by row order.
	always_comb begin
		for (int i = 0; i < ROW_COUNT; i++) begin
			rank[i] = '0;
			for (int j = 0; j < ROW_COUNT; j++) begin
				if ((remap[j] < remap[i]) || ((remap[j] == remap[i]) && (j < i))) begin
					rank[i] = rank[i] + RW'(1);
				end
			end
		end
	end

	always_comb begin
		sorted = '0;
		for (int k = 0; k < ROW_COUNT; k++) begin
			for (int i = 0; i < ROW_COUNT; i++) begin
				if (rank[i] == RW'(k)) begin
					sorted[bmc_pkg::NIBBLE_W*(ROW_COUNT-1-k) +: bmc_pkg::NIBBLE_W] =
						sorted[bmc_pkg::NIBBLE_W*(ROW_COUNT-1-k) +: bmc_pkg::NIBBLE_W]
						| remap[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		key_s2 <= sorted;
	end

endmodule

[hw/rtl/bmc_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_merge: pipelined minimum over the lane keys.
// A binary tree with a register after every compare level; unused leaves hold the
// largest key so they never win.
// ----------------------------------------------------------------------------
module bmc_merge #(
	parameter int ROW_COUNT = bmc_pkg::ROW_COUNT_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [bmc_pkg::NIBBLE_W*ROW_COUNT-1:0] lane_key [bmc_pkg::LANE_COUNT],
	output logic                                   out_valid,
	output logic [bmc_pkg::NIBBLE_W*ROW_COUNT-1:0] out_key
);

	localparam int KW = bmc_pkg::NIBBLE_W * ROW_COUNT;
	localparam int MW = bmc_pkg::MERGE_WIDTH;
	localparam int ML = bmc_pkg::MERGE_LEVELS;

	logic [KW-1:0] leaf   [MW];
	logic [KW-1:0] node_q [MW-1];
	logic [ML-1:0] valid_q;

	for (genvar i = 0; i < MW; i++) begin : g_leaf
		if (i < bmc_pkg::LANE_COUNT) begin : g_lane
			assign leaf[i] = lane_key[i];
		end else begin : g_pad
			assign leaf[i] = '1;
		end
	end

	for (genvar n = 0; n < MW - 1; n++) begin : g_node
		logic [KW-1:0] left;
		logic [KW-1:0] right;
		if (2*n + 1 >= MW - 1) begin : g_from_leaf
			assign left  = leaf[2*n + 1 - (MW - 1)];
			assign right = leaf[2*n + 2 - (MW - 1)];
		end else begin : g_from_node
			assign left  = node_q[2*n + 1];
			assign right = node_q[2*n + 2];
		end
		always_ff @(posedge clk) begin
			node_q[n] <= (right < left) ? right : left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[ML-2:0], in_valid};
		end
	end

	assign out_valid = valid_q[ML-1];
	assign out_key   = node_q[0];

endmodule

[hw/rtl/binary_matrix_canonicalizer_8x4_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_matrix_canonicalizer_8x4_top: canonical key of a binary matrix.
// Returns the smallest packed key over all column orderings, rows sorted.
//
//   Port group     Dir  Handshake            Width
//   start/rows_key in   start && !busy       32
//   done/canon.key out  done, one cycle      32
//
// A word is taken every cycle; busy is always low. After acceptance the result
// passes through one input register, one lane register and five levels of
// the compare tree. Reset clears only the valid pipeline. The receiver cannot
// stall, so nothing ever holds the pipeline.
// ----------------------------------------------------------------------------
module binary_matrix_canonicalizer_8x4_top #(
	parameter int ROW_COUNT = bmc_pkg::ROW_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [bmc_pkg::KEY_W-1:0] rows_key,
	output logic                      done,
	output logic [bmc_pkg::KEY_W-1:0] canonical_key
);

	localparam int KW = bmc_pkg::NIBBLE_W * ROW_COUNT;

	logic [bmc_pkg::KEY_W-1:0] key_s1;
	logic                      valid_s1;
	logic                      valid_s2;
	logic [KW-1:0]             lane_key [bmc_pkg::LANE_COUNT];
	logic [KW-1:0]             merged_key;

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_s1 <= rows_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	for (genvar l = 0; l < bmc_pkg::LANE_COUNT; l++) begin : g_lane
		bmc_lane #(
			.ROW_COUNT (ROW_COUNT),
			.LANE_INDEX(l)
		) u_lane (
			.clk   (clk),
			.key_s1(key_s1),
			.key_s2(lane_key[l])
		);
	end

	bmc_merge #(
		.ROW_COUNT(ROW_COUNT)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.lane_key (lane_key),
		.out_valid(done),
		.out_key  (merged_key)
	);

	assign canonical_key = bmc_pkg::KEY_W'(merged_key);

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(bmc_pkg::LATENCY) done)
		else $error("Accepted word did not produce a result on time.");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, bmc_pkg::LATENCY))
		else $error("Result strobe without a matching accepted word.");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("Lane stage valid without input stage valid.");

endmodule
